// ----- sv/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions of the text console writer
// Screen geometry, field widths, item action codes and the control bundle
// that the cursor unit hands to the top level.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_hit;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic              scrolled;
  } tcw_ctl_t;

endpackage

// ----- sv/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/tcw_cursor.sv -----
// ----------------------------------------------------------------------------
// tcw_cursor: cursor, scroll ring and cell addressing
// Holds the cursor and the physical row that shows as the top line. Maps
// logical cells to RAM addresses and decides whether a read hits a cell
// written since the last clear.
// ----------------------------------------------------------------------------
module tcw_cursor
  import tcw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [1:0]       action,
  input  logic [ROW_W-1:0] read_row,
  input  logic [COL_W-1:0] read_col,
  output tcw_ctl_t         ctl
);

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   wr_sum, rd_sum;
  logic [ROW_W-1:0] wr_phys, rd_phys;
  logic             rd_in_range, rd_filled;

  // Logical row plus ring offset, folded back once into 0..ROWS-1.
  always_comb begin
    wr_sum  = {1'b0, row_r} + {1'b0, top_r};
    rd_sum  = {1'b0, read_row} + {1'b0, top_r};
    wr_phys = (wr_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(wr_sum - (ROW_W+1)'(ROWS))
                                           : ROW_W'(wr_sum);
    rd_phys = (rd_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(rd_sum - (ROW_W+1)'(ROWS))
                                           : ROW_W'(rd_sum);
  end

  // Cells are written strictly in order from home, so exactly the cells
  // before the cursor hold live data; every other cell reads as zero.
  assign rd_in_range = (read_row < ROW_W'(ROWS)) && ({1'b0, read_col} < (COL_W+1)'(COLUMNS));
  assign rd_filled   = (read_row < row_r) || ((read_row == row_r) && (read_col < col_r));

  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    top_nxt      = top_r;
    col_inc      = {1'b0, col_r} + 1'b1;
    ctl.scrolled = 1'b0;
    ctl.wr_en    = 1'b0;
    ctl.rd_en    = 1'b0;
    ctl.rd_hit   = 1'b0;
    case (action)
      ACT_PUT: begin
        ctl.wr_en = 1'b1;
        if (col_inc == (COL_W+1)'(COLUMNS)) begin
          col_nxt = '0;
          if (row_r == ROW_W'(ROWS - 1)) begin
            ctl.scrolled = 1'b1;
            top_nxt      = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          col_nxt = COL_W'(col_inc);
        end
      end
      ACT_CLEAR: begin
        row_nxt = '0;
        col_nxt = '0;
        top_nxt = '0;
      end
      ACT_READ: begin
        ctl.rd_en  = rd_in_range;
        ctl.rd_hit = rd_in_range && rd_filled;
      end
      default: begin
      end
    endcase
    ctl.wr_addr = ADDR_W'(wr_phys) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
    ctl.rd_addr = rd_in_range ? ADDR_W'(rd_phys) * ADDR_W'(COLUMNS) + ADDR_W'(read_col)
                              : '0;
    ctl.cur_row = row_nxt;
    ctl.cur_col = col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      top_r <= '0;
    end else if (step) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      top_r <= top_nxt;
    end
  end

endmodule

// ----- sv/text_console_writer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_top: text-mode console writer
// Puts characters at a cursor, scrolls and clears the screen, and reads one
// cell for scan-out. The screen lives in one RAM addressed through a ring of
// rows, so scroll and clear move no screen data.
//
//   channel  direction  handshake          payload
//   in_      in         in_valid/in_stall  action, char_code, read_row,
//                                          read_col
//   out_     out        out_valid/out_stall cell_char, cell_attr,
//                                          cursor_row, cursor_col, scrolled
//   cfg_     in         cfg_valid/cfg_ready text_attribute
//
// One item is accepted per cycle while the input is not stalled; its result
// passes the registered RAM read, alongside stage one, and then the output register.
// Reset takes no clearing pass: the cursor marks how far the screen has been
// written since the last clear, and cells past it read as zero.
// A stalled output holds the result, the RAM read register holds the next
// one, and the input stalls only when both are occupied.
// ----------------------------------------------------------------------------
module text_console_writer_top
  import tcw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_action,
  input  logic [7:0]       in_char_code,
  input  logic [ROW_W-1:0] in_read_row,
  input  logic [COL_W-1:0] in_read_col,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_cell_char,
  output logic [7:0]       out_cell_attr,
  output logic [ROW_W-1:0] out_cursor_row,
  output logic [COL_W-1:0] out_cursor_col,
  output logic             out_scrolled,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_text_attribute
);

  tcw_ctl_t          ctl;
  logic              accept;
  logic              out_free, s1_free;
  logic [CELL_W-1:0] rdata;
  logic [7:0]        attr_r;

  // Stage one sits alongside the RAM read register and carries the rest of
  // the result; the output register follows it.
  logic             s1_valid_r;
  logic             s1_hit_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_scrolled_r;

  logic             out_valid_r;
  logic [7:0]       out_char_r, out_attr_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_scrolled_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_stall = !s1_free;
  assign accept   = in_valid && s1_free;

  tcw_cursor u_cursor (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (accept),
    .action   (in_action),
    .read_row (in_read_row),
    .read_col (in_read_col),
    .ctl      (ctl)
  );

  // The read data register only loads on an accepted read, so it keeps the
  // cell for stage one for as long as stage one waits on the output.
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (accept && ctl.wr_en),
    .waddr (ctl.wr_addr),
    .wdata ({attr_r, in_char_code}),
    .re    (accept && ctl.rd_en),
    .raddr (ctl.rd_addr),
    .rdata (rdata)
  );

  // The attribute register is written whenever asked; writes only come while
  // the block is idle, a rule for the user that the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_valid) begin
      attr_r <= cfg_text_attribute;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_hit_r      <= ctl.rd_hit;
      s1_row_r      <= ctl.cur_row;
      s1_col_r      <= ctl.cur_col;
      s1_scrolled_r <= ctl.scrolled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
    if (out_free && s1_valid_r) begin
      out_char_r     <= s1_hit_r ? rdata[7:0]  : 8'h00;
      out_attr_r     <= s1_hit_r ? rdata[15:8] : 8'h00;
      out_row_r      <= s1_row_r;
      out_col_r      <= s1_col_r;
      out_scrolled_r <= s1_scrolled_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_scrolled   = out_scrolled_r;

  // The cursor shown with a result always lies on the screen.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_row_r < ROW_W'(ROWS)) &&
                    ({1'b0, out_col_r} < (COL_W+1)'(COLUMNS)))
    else $error("cursor outside the screen");

  // A scroll leaves the cursor at the start of the bottom row.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_scrolled_r |->
      (out_row_r == ROW_W'(ROWS - 1)) && (out_col_r == '0))
    else $error("scroll left the cursor elsewhere");

  // The input is only held off while both pipeline registers are full.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  // Stage one is never dropped while the output waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r)
    else $error("pending result lost under stall");

endmodule

// ----- tb/tb_text_console_writer_top.sv -----
// ----------------------------------------------------------------------------
// tb_text_console_writer_top: self-checking bench of the text console writer
// Drives put, clear, read and unused items into the console and keeps a
// mirror of the screen, the cursor and the attribute register. Every result
// is checked field by field against the mirror's prediction. The run covers
// empty-screen reads, reads out of range, attribute extremes, clears, row
// wrap, random idling on both channels and a long receiver hold-off that
// fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_text_console_writer_top;
  import tcw_pkg::*;

  // Action code that the block must ignore.
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 160;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             scrolled;
  } console_report_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_action = ACT_PUT;
  logic [7:0]       in_char_code = 8'h00;
  logic [ROW_W-1:0] in_read_row = '0;
  logic [COL_W-1:0] in_read_col = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_cell_char;
  logic [7:0]       out_cell_attr;
  logic [ROW_W-1:0] out_cursor_row;
  logic [COL_W-1:0] out_cursor_col;
  logic             out_scrolled;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [7:0]       cfg_text_attribute = 8'h00;

  // Mirror of the console: screen cells, cursor and current attribute.
  logic [15:0] screen_copy [CELLS];
  int          row_pos;
  int          col_pos;
  logic [7:0]  attr_copy;

  // Reports predicted at input acceptance, oldest first.
  console_report_t console_reports [$];

  int fail_count = 0;
  int cycle_count = 0;

  // Idling controls shared by the stimulus and the result side.
  int send_gap_pct = 0;
  bit stall_gaps_on = 1'b0;
  int hold_request = 0;

  text_console_writer_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_char_code       (in_char_code),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cell_char      (out_cell_char),
    .out_cell_attr      (out_cell_attr),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_col     (out_cursor_col),
    .out_scrolled       (out_scrolled),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_text_attribute (cfg_text_attribute)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Zeroes the mirrored screen and homes the cursor, as reset and clear do.
  function automatic void wipe_screen_copy();
    for (int i = 0; i < CELLS; i++) begin
      screen_copy[i] = 16'h0000;
    end
    row_pos = 0;
    col_pos = 0;
  endfunction

  // Applies one accepted item to the mirror and returns the report that the
  // block must produce for it.
  function automatic console_report_t advance_console(
    input logic [1:0]       act,
    input logic [7:0]       ch,
    input logic [ROW_W-1:0] rd_row,
    input logic [COL_W-1:0] rd_col
  );
    console_report_t rep;
    int              pos;
    rep = '0;
    case (act)
      ACT_PUT: begin
        pos = row_pos * COLUMNS + col_pos;
        if (pos < CELLS) begin
          screen_copy[pos] = {attr_copy, ch};
        end
        col_pos++;
        if (col_pos >= COLUMNS) begin
          col_pos = 0;
          row_pos++;
        end
        // Moving past the last row shifts everything up by one row and
        // leaves an empty bottom row under the cursor.
        if (row_pos >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen_copy[i] = screen_copy[i + COLUMNS];
          end
          for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen_copy[i] = 16'h0000;
          end
          row_pos = ROWS - 1;
          rep.scrolled = 1'b1;
        end
      end
      ACT_CLEAR: begin
        wipe_screen_copy();
      end
      ACT_READ: begin
        // Reads outside the screen return an empty cell.
        if (rd_row < ROWS && rd_col < COLUMNS) begin
          pos = int'(rd_row) * COLUMNS + int'(rd_col);
          rep.cell_char = screen_copy[pos][7:0];
          rep.cell_attr = screen_copy[pos][15:8];
        end
      end
      default: begin
        // The unused action leaves the console untouched.
      end
    endcase
    rep.cursor_row = ROW_W'(row_pos);
    rep.cursor_col = COL_W'(col_pos);
    return rep;
  endfunction

  // Offers one item, optionally after a random gap, and records its
  // prediction at the edge where the block takes it.
  task automatic send_item(
    input logic [1:0]       act,
    input logic [7:0]       ch,
    input logic [ROW_W-1:0] rd_row,
    input logic [COL_W-1:0] rd_col
  );
    int gap;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_char_code <= ch;
    in_read_row  <= rd_row;
    in_read_col  <= rd_col;
    do @(posedge clk); while (in_stall);
    console_reports.push_back(advance_console(act, ch, rd_row, rd_col));
  endtask

  // Picks an action by the given weights; read fields mostly land on rows
  // that have been written, sometimes anywhere in their full range.
  task automatic send_random_item(input int put_pct, input int clear_pct,
                                  input int noise_pct);
    int               pick;
    logic [1:0]       act;
    logic [ROW_W-1:0] rd_row;
    logic [COL_W-1:0] rd_col;
    pick = $urandom_range(0, 99);
    if (pick < put_pct) act = ACT_PUT;
    else if (pick < put_pct + clear_pct) act = ACT_CLEAR;
    else if (pick < put_pct + clear_pct + noise_pct) act = ACT_NONE;
    else act = ACT_READ;
    if ($urandom_range(0, 9) == 0) begin
      rd_row = ROW_W'($urandom_range(0, 31));
      rd_col = COL_W'($urandom_range(0, 127));
    end else begin
      rd_row = ROW_W'($urandom_range(0, row_pos));
      rd_col = COL_W'($urandom_range(0, COLUMNS - 1));
    end
    send_item(act, 8'($urandom_range(0, 255)), rd_row, rd_col);
  endtask

  // The attribute register is only written with the block drained, so no
  // item in flight can see the change.
  task automatic write_attribute(input logic [7:0] value);
    in_valid <= 1'b0;
    while (console_reports.size() != 0) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_text_attribute <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    attr_copy = value;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: checks each taken item against the oldest prediction and
  // drives out_stall, either in short random bursts or in one long hold
  // when a test asks for it.
  initial begin : result_side
    int              stall_left;
    console_report_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (console_reports.size() == 0) begin
          $error("result item with no prediction waiting");
          fail_count++;
        end else begin
          want = console_reports.pop_front();
          check_field("cell_char", want.cell_char, out_cell_char);
          check_field("cell_attr", want.cell_attr, out_cell_attr);
          check_field("cursor_row", want.cursor_row, out_cursor_row);
          check_field("cursor_col", want.cursor_col, out_cursor_col);
          check_field("scrolled", want.scrolled, out_scrolled);
        end
      end
      if (stall_left == 0) begin
        if (hold_request > 0) begin
          stall_left   = hold_request;
          hold_request = 0;
        end else if (stall_gaps_on && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 18);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Right after reset every cell is empty, and reads past the last row or
  // column come back empty whatever the screen holds.
  task automatic test_empty_screen_reads();
    send_item(ACT_READ, 8'h00, ROW_W'(0), COL_W'(0));
    send_item(ACT_READ, 8'hFF, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
    send_item(ACT_READ, 8'h00, '1, '1);
    send_item(ACT_READ, 8'h00, ROW_W'(ROWS), COL_W'(0));
    send_item(ACT_READ, 8'h00, ROW_W'(0), COL_W'(COLUMNS));
  endtask

  // The unused action must not move the cursor or touch the screen.
  task automatic test_unused_action();
    send_item(ACT_NONE, 8'hFF, '1, '1);
    send_item(ACT_NONE, 8'h00, '0, '0);
  endtask

  // Character extremes with the reset attribute, then the attribute at both
  // of its extremes, each read back from the cell it landed in.
  task automatic test_put_and_attribute();
    send_item(ACT_PUT, 8'h00, '1, '1);
    send_item(ACT_PUT, 8'hFF, '0, '0);
    send_item(ACT_READ, 8'h00, ROW_W'(0), COL_W'(0));
    send_item(ACT_READ, 8'h00, ROW_W'(0), COL_W'(1));
    write_attribute(8'hFF);
    send_item(ACT_PUT, 8'h41, '0, '0);
    send_item(ACT_READ, 8'h00, ROW_W'(0), COL_W'(2));
    write_attribute(8'h00);
    send_item(ACT_PUT, 8'h7E, '0, '0);
    send_item(ACT_READ, 8'h00, ROW_W'(0), COL_W'(3));
  endtask

  // A clear empties the written cells and homes the cursor.
  task automatic test_clear_screen();
    send_item(ACT_CLEAR, 8'hA5, ROW_W'(3), COL_W'(7));
    send_item(ACT_READ, 8'h00, ROW_W'(0), COL_W'(0));
    send_item(ACT_READ, 8'h00, ROW_W'(0), COL_W'(3));
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the block's internal registers fill and the input has to stall.
  task automatic test_input_backpressure();
    write_attribute(8'h1E);
    send_gap_pct  = 0;
    stall_gaps_on = 1'b0;
    hold_request  = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) begin
      send_random_item(70, 0, 0);
    end
  endtask

  // Mixed traffic with clears, in short phases at different attributes and
  // idling rates.
  task automatic test_mixed_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      write_attribute(8'($urandom_range(0, 255)));
      send_gap_pct  = (phase == 2) ? 0 : 25;
      stall_gaps_on = (phase != 3);
      for (int i = 0; i < 50; i++) begin
        send_random_item(60, 4, 3);
      end
    end
  endtask

  // Long runs of puts with no clear: the cursor wraps at every row end. The
  // last phases run without idling on either side.
  task automatic test_row_wrap();
    logic [7:0] attr_steps [4] = '{8'h00, 8'hFF, 8'h0F, 8'hF0};
    for (int phase = 0; phase < 8; phase++) begin
      write_attribute(phase < 4 ? attr_steps[phase] : 8'($urandom_range(0, 255)));
      send_gap_pct  = (phase < 6 && phase != 2) ? 20 : 0;
      stall_gaps_on = (phase < 6 && phase != 2);
      for (int i = 0; i < 107; i++) begin
        send_random_item(90, 0, 1);
      end
    end
  endtask

  initial begin
    wipe_screen_copy();
    attr_copy = ATTR_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_screen_reads();
    test_unused_action();
    test_put_and_attribute();
    test_clear_screen();
    test_input_backpressure();
    test_mixed_traffic();
    test_row_wrap();

    in_valid <= 1'b0;
    while (console_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
